FILE: src/omsk_pkg.sv
// ----------------------------------------------------------------------------
// omsk_pkg: shared types for the order statistic multiset
// Beat formats of both channels, status codes, cell control and FSM states.
// ----------------------------------------------------------------------------
package omsk_pkg;

    // operation codes of the input beat
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_ERASE  = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_BAD_RANK = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] key;
        logic [8:0]         rank;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [8:0]         size;
    } t_out_beat;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] key;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_QSEL
    } t_state;

endpackage

FILE: src/order_statistic_multiset_top.sv
// Insert and a query with a bad rank pass through S_EXEC to the output register,
// an erase stays in S_EXEC while copies remain, and a good query adds S_QSEL.
// One operation is in flight at a time: the next beat is taken only back in S_IDLE.
// Erase removes one copy per cycle by shifting the chain down by one cell.
// Query reads the chosen cell through a one-hot OR select in its own cycle.
// Reset (synchronous, i_rst_n low) empties the store; cell contents are not cleared.
// ----------------------------------------------------------------------------
// order_statistic_multiset_top: sorted multiset with k-th largest query
// A chain of CAPACITY cells holds the keys in ascending order, below a count.
// ----------------------------------------------------------------------------
module order_statistic_multiset_top #(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  omsk_pkg::t_in_beat i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output omsk_pkg::t_out_beat o_out
);
    import omsk_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int RW = (CW > 9) ? CW : 9;

    t_state    r_state, n_state;
    t_in_beat  r_in;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_sel, n_sel;
    logic      r_ovalid;
    t_out_beat r_out;

    t_cell_ctl          w_ctl;
    logic [CAPACITY-1:0] w_valid, w_stay, w_match;
    logic signed [31:0] w_key [CAPACITY];
    logic signed [31:0] w_pick;
    logic               w_hit, w_full, w_bad, w_out_free, w_produce;
    logic [RW-1:0]      w_rank_x, w_count_x;
    t_out_beat          w_res;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_valid[g] = CW'(g) < r_count;
        if (g == 0) begin : g_first
            omsk_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_valid     (w_valid[g]),
                .i_below_key (w_ctl.key),
                .i_below_stay(1'b1),
                .i_above_key (w_key[(g + 1) % CAPACITY]),
                .o_key       (w_key[g]),
                .o_stay      (w_stay[g]),
                .o_match     (w_match[g])
            );
        end else if (g == CAPACITY - 1) begin : g_last
            omsk_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_valid     (w_valid[g]),
                .i_below_key (w_key[g - 1]),
                .i_below_stay(w_stay[g - 1]),
                .i_above_key (w_key[g]),
                .o_key       (w_key[g]),
                .o_stay      (w_stay[g]),
                .o_match     (w_match[g])
            );
        end else begin : g_mid
            omsk_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_valid     (w_valid[g]),
                .i_below_key (w_key[g - 1]),
                .i_below_stay(w_stay[g - 1]),
                .i_above_key (w_key[g + 1]),
                .o_key       (w_key[g]),
                .o_stay      (w_stay[g]),
                .o_match     (w_match[g])
            );
        end
    end

    // status terms
    assign w_hit      = |w_match;
    assign w_full     = r_count == CW'(CAPACITY);
    assign w_rank_x   = RW'(r_in.rank);
    assign w_count_x  = RW'(r_count);
    assign w_bad      = (r_in.rank == 9'd0) || (w_rank_x > w_count_x);
    assign w_out_free = !r_ovalid || !i_out_stall;

    // one-hot select of the queried cell
    always_comb begin
        w_pick = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_sel == IW'(i)) begin
                w_pick = w_pick | w_key[i];
            end
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // sequencer: next state, cell control and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sel     = r_sel;
        w_ctl.op  = CELL_HOLD;
        w_ctl.key = r_in.key;
        w_produce = 1'b0;
        w_res     = '{value: '0, status: STAT_OK, size: 9'(r_count)};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_in.func)
                    FUNC_INSERT: begin
                        if (w_out_free) begin
                            w_produce = 1'b1;
                            n_state   = S_IDLE;
                            if (w_full) begin
                                w_res.status = STAT_FULL;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + CW'(1);
                            end
                        end
                    end
                    FUNC_ERASE: begin
                        if (w_hit) begin
                            w_ctl.op = CELL_ERASE;
                            n_count  = r_count - CW'(1);
                        end else if (w_out_free) begin
                            w_produce = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    FUNC_QUERY: begin
                        if (!w_bad) begin
                            n_sel   = IW'(w_count_x - w_rank_x);
                            n_state = S_QSEL;
                        end else if (w_out_free) begin
                            w_produce    = 1'b1;
                            w_res.status = STAT_BAD_RANK;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        if (w_out_free) begin
                            w_produce = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                endcase
                w_res.size = 9'(n_count);
            end
            S_QSEL: begin
                if (w_out_free) begin
                    w_produce   = 1'b1;
                    w_res.value = w_pick;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_produce) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_produce) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

FILE: src/omsk_cell.sv
// ----------------------------------------------------------------------------
// omsk_cell: one slot of the sorted key chain
// Holds one key, compares it with the broadcast key, and on insert takes the
// new key or its lower neighbor; on erase takes its upper neighbor.
// ----------------------------------------------------------------------------
module omsk_cell (
    input  logic               i_clk,
    input  omsk_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  logic signed [31:0] i_below_key,
    input  logic               i_below_stay,
    input  logic signed [31:0] i_above_key,
    output logic signed [31:0] o_key,
    output logic               o_stay,
    output logic               o_match
);
    import omsk_pkg::*;

    logic signed [31:0] r_key;
    logic signed [31:0] n_key;
    logic               w_ge;

    // compare against the broadcast key
    assign o_stay  = i_valid && (r_key <= i_ctl.key);
    assign w_ge    = i_valid && (r_key >= i_ctl.key);
    assign o_match = i_valid && (r_key == i_ctl.key);
    assign o_key   = r_key;

    // next key: shift up on insert, shift down on erase
    always_comb begin
        n_key = r_key;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (!o_stay) begin
                    n_key = i_below_stay ? i_ctl.key : i_below_key;
                end
            end
            CELL_ERASE: begin
                if (w_ge) begin
                    n_key = i_above_key;
                end
            end
            default: n_key = r_key;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule
